### hw/rtl/fram_pkg.sv
// ----------------------------------------------------------------------------
// fram_pkg
// Shared types and constants for the four-register accumulator machine.
// ----------------------------------------------------------------------------
package fram_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int NUM_REGS   = 4;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        OP_IN  = 3'd0,
        OP_MOV = 3'd1,
        OP_ADD = 3'd2,
        OP_SUB = 3'd3,
        OP_MUL = 3'd4,
        OP_DIV = 3'd5,
        OP_OUT = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_IMM,
        WR_MOV,
        WR_ADD,
        WR_SUB,
        WR_MUL,
        WR_DIV
    } wr_sel_t;

    typedef struct packed {
        logic [2:0]                mode;
        logic [1:0]                dest_reg;
        logic [1:0]                src_reg;
        logic signed [FIELD_W-1:0] immediate;
    } cmd_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      is_fault;
    } res_t;

    // Controller to datapath.
    typedef struct packed {
        logic    load;
        wr_sel_t wr_sel;
        logic    div_init;
        logic    mul_step;
        logic    div_step;
        logic    emit;
        logic    emit_fault;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        op_t  op;
        logic same_reg;
        logic src_zero;
        logic out_busy;
    } dp_status_t;

endpackage

### hw/rtl/four_register_alu_machine_unit.sv
// ----------------------------------------------------------------------------
// four_register_alu_machine_unit
// Four-register accumulator machine with iterative multiply and divide.
// ----------------------------------------------------------------------------
// Each request is one instruction on the signed registers A to D. IN, MOV,
// ADD, SUB, an unused mode and a MUL or DIV whose source equals its
// destination pass through decode and return to idle, where the
// next request can be taken. OUT and a refused divide by zero also wait in
// the emit state for the output slot, which holds one result and lets the
// next request in while that result is stalled. MUL and DIV run in the
// shift-add multiplier and the restoring divider, which each resolve one
// bit per cycle over 32 steps. Registers reset to zero.
module four_register_alu_machine_unit
    import fram_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    dp_cmd_t    ctl;
    dp_status_t st;

    fram_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .st        (st),
        .ctl       (ctl)
    );

    fram_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .st        (st),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### hw/rtl/fram_ctrl.sv
// ----------------------------------------------------------------------------
// fram_ctrl
// Sequencer: accepts a request, decodes it and steps the datapath.
// ----------------------------------------------------------------------------
module fram_ctrl
    import fram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  dp_status_t st,
    output dp_cmd_t    ctl
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_DIVFIX = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fault_reg, fault_next;

    assign cmd_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fault_next = fault_reg;
        ctl        = '0;
        ctl.wr_sel = WR_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cnt_next   = '0;
                state_next = ST_IDLE;
                unique case (st.op) inside
                    OP_IN:
                        ctl.wr_sel = WR_IMM;
                    OP_OUT:
                    begin
                        fault_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    OP_MOV, OP_ADD, OP_SUB:
                    begin
                        if (!st.same_reg)
                        begin
                            ctl.wr_sel = (st.op == OP_MOV) ? WR_MOV :
                                         (st.op == OP_ADD) ? WR_ADD : WR_SUB;
                        end
                    end
                    OP_MUL:
                    begin
                        if (!st.same_reg)
                        begin
                            state_next = ST_MUL;
                        end
                    end
                    OP_DIV:
                    begin
                        if (!st.same_reg)
                        begin
                            if (st.src_zero)
                            begin
                                fault_next = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                ctl.div_init = 1'b1;
                                state_next   = ST_DIV;
                            end
                        end
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_MUL:
            begin
                ctl.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    ctl.wr_sel = WR_MUL;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DIVFIX;
                end
            end
            ST_DIVFIX:
            begin
                ctl.wr_sel = WR_DIV;
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!st.out_busy)
                begin
                    ctl.emit       = 1'b1;
                    ctl.emit_fault = fault_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fault_reg <= fault_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted request did not move to decode");

    a_iter_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL || state_reg == ST_DIV) && state_next != state_reg)
        |-> (cnt_reg == CNT_LAST))
        else $error("iteration left before the last bit");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> !st.out_busy)
        else $error("result emitted into an occupied output slot");

    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (ctl.wr_sel == WR_NONE))
        else $error("register write while emitting a result");
`endif

endmodule

### hw/rtl/fram_dp.sv
// ----------------------------------------------------------------------------
// fram_dp
// Register file, shift-add multiplier, restoring divider and output slot.
// ----------------------------------------------------------------------------
module fram_dp
    import fram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  dp_cmd_t    ctl,
    output dp_status_t st,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res
);

    word_t                     regs_reg [NUM_REGS];
    op_t                       op_reg;
    logic [IDX_W-1:0]          dst_reg, src_reg;
    logic signed [FIELD_W-1:0] imm_reg;
    word_t                     a_reg, b_reg, acc_reg, rem_reg;
    logic                      neg_reg;
    logic                      res_valid_reg;
    res_t                      res_reg;

    word_t                     wr_data;
    word_t                     mul_sum;
    logic [DATA_WIDTH:0]       trial;
    logic [DATA_WIDTH:0]       shifted;
    logic signed [DATA_WIDTH-1:0] a_signed;

    assign mul_sum  = acc_reg + (b_reg[0] ? a_reg : '0);
    assign shifted  = {rem_reg, a_reg[DATA_WIDTH-1]};
    assign trial    = shifted - {1'b0, b_reg};
    assign a_signed = a_reg;

    assign st.op       = op_reg;
    assign st.same_reg = (dst_reg == src_reg);
    assign st.src_zero = (b_reg == '0);
    assign st.out_busy = res_valid_reg && res_stall;

    always_comb
    begin
        case (ctl.wr_sel)
            WR_IMM:  wr_data = DATA_WIDTH'(imm_reg);
            WR_MOV:  wr_data = b_reg;
            WR_ADD:  wr_data = a_reg + b_reg;
            WR_SUB:  wr_data = a_reg - b_reg;
            WR_MUL:  wr_data = mul_sum;
            WR_DIV:  wr_data = neg_reg ? (word_t'(0) - a_reg) : a_reg;
            default: wr_data = a_reg;
        endcase
    end

    // Register file: both operands are read into a_reg and b_reg on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (ctl.wr_sel != WR_NONE)
        begin
            regs_reg[dst_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= op_t'(cmd.mode);
            dst_reg <= cmd.dest_reg;
            src_reg <= cmd.src_reg;
            imm_reg <= cmd.immediate;
            a_reg   <= regs_reg[cmd.dest_reg];
            b_reg   <= regs_reg[cmd.src_reg];
            acc_reg <= '0;
        end
        else if (ctl.div_init)
        begin
            a_reg   <= a_reg[DATA_WIDTH-1] ? (word_t'(0) - a_reg) : a_reg;
            b_reg   <= b_reg[DATA_WIDTH-1] ? (word_t'(0) - b_reg) : b_reg;
            rem_reg <= '0;
            neg_reg <= a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
        end
        else if (ctl.mul_step)
        begin
            acc_reg <= mul_sum;
            a_reg   <= {a_reg[DATA_WIDTH-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[DATA_WIDTH-1:1]};
        end
        else if (ctl.div_step)
        begin
            // One quotient bit per cycle; the dividend shifts out of a_reg
            // while the quotient shifts in behind it.
            if (!trial[DATA_WIDTH])
            begin
                rem_reg <= trial[DATA_WIDTH-1:0];
                a_reg   <= {a_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_WIDTH-1:0];
                a_reg   <= {a_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res_reg.is_fault <= ctl.emit_fault;
            res_reg.value    <= ctl.emit_fault ? '0 : FIELD_W'(a_signed);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(res_valid_reg) |-> $past(!res_stall))
        else $error("pending result dropped while stalled");

    a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (ctl.wr_sel == WR_NONE))
        else $error("register write together with a result");

    a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.mul_step && ctl.div_step))
        else $error("multiply and divide stepping at once");
`endif

endmodule

### tb/four_register_alu_machine_checker.sv
// ----------------------------------------------------------------------------
// four_register_alu_machine_checker
// Predicts and checks the results of the four-register accumulator machine.
// ----------------------------------------------------------------------------
// Each request accepted on the command channel is run on a shadow copy of the
// registers. The result that an OUT or a refused divide by zero should produce
// is queued. Every result accepted on the output channel is compared field by
// field with the oldest queued result.
module four_register_alu_machine_checker
    import fram_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    word_t shadow_regs [NUM_REGS];
    res_t  pending_outputs [$];

    // Signed division on magnitudes, truncating toward zero. The minimum value
    // divided by minus one comes out as the minimum again.
    function automatic word_t quotient(word_t num, word_t den);
        logic  num_neg;
        logic  den_neg;
        word_t num_mag;
        word_t den_mag;
        word_t q;
        num_neg = num[DATA_WIDTH-1];
        den_neg = den[DATA_WIDTH-1];
        num_mag = num_neg ? -num : num;
        den_mag = den_neg ? -den : den;
        q = num_mag / den_mag;
        return (num_neg != den_neg) ? -q : q;
    endfunction

    function automatic void execute_instr(cmd_t c);
        word_t dst;
        word_t src;
        res_t  out;
        dst = shadow_regs[c.dest_reg];
        src = shadow_regs[c.src_reg];
        out = '0;
        if (c.mode == OP_IN)
        begin
            shadow_regs[c.dest_reg] = word_t'(c.immediate);
        end
        else if (c.mode == OP_OUT)
        begin
            out.value = FIELD_W'($signed(dst));
            pending_outputs.push_back(out);
        end
        else if (c.dest_reg != c.src_reg)
        begin
            case (c.mode)
                OP_MOV: shadow_regs[c.dest_reg] = src;
                OP_ADD: shadow_regs[c.dest_reg] = dst + src;
                OP_SUB: shadow_regs[c.dest_reg] = dst - src;
                OP_MUL: shadow_regs[c.dest_reg] = dst * src;
                OP_DIV:
                begin
                    if (src == '0)
                    begin
                        out.is_fault = 1'b1;
                        pending_outputs.push_back(out);
                    end
                    else
                    begin
                        shadow_regs[c.dest_reg] = quotient(dst, src);
                    end
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    always @(posedge clk)
    begin
        int   bad;
        res_t want;
        bad = 0;
        if (!rst_n)
        begin
            foreach (shadow_regs[i])
                shadow_regs[i] = '0;
            pending_outputs.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("result with nothing expected: value %0d is_fault %0b",
                           res.value, res.is_fault);
                    bad++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (res.value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d", want.value, res.value);
                        bad++;
                    end
                    if (res.is_fault !== want.is_fault)
                    begin
                        $error("is_fault: expected %0b, actual %0b",
                               want.is_fault, res.is_fault);
                        bad++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                execute_instr(cmd);
            errors  <= errors + bad;
            pending <= pending_outputs.size();
        end
    end

endmodule

### tb/four_register_alu_machine_unit_tb.sv
// ----------------------------------------------------------------------------
// four_register_alu_machine_unit_tb
// Testbench for the four-register accumulator machine.
// ----------------------------------------------------------------------------
// A directed program covers the value extremes, every operation, same source
// and destination, divide by zero, minimum over minus one and the unused mode.
// It is followed by random instruction streams with random gaps on the command
// side and random stalls on the result side. A checker beside the block
// predicts and compares the results; this module gives the verdict.
module four_register_alu_machine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fram_pkg::*;

    localparam int         ITEM_COUNT   = 1200;
    localparam int         STUCK_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 40;
    localparam logic [2:0] MODE_UNUSED  = 3'd7;
    localparam logic [1:0] REG_A        = 2'd0;
    localparam logic [1:0] REG_B        = 2'd1;
    localparam logic [1:0] REG_C        = 2'd2;
    localparam logic [1:0] REG_D        = 2'd3;
    localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_ONES   = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic calm;
    int   errors;
    int   pending;

    four_register_alu_machine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    four_register_alu_machine_checker alu_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic cmd_t instr(logic [2:0] mode, logic [1:0] dst, logic [1:0] src,
                                   logic [31:0] imm);
        cmd_t c;
        c.mode      = mode;
        c.dest_reg  = dst;
        c.src_reg   = src;
        c.immediate = imm;
        return c;
    endfunction

    // Operands lean toward small values and extremes so that zero divisors,
    // wraparound and sign handling come up often.
    function automatic cmd_t random_instr();
        int   pick;
        cmd_t c;
        c.dest_reg = 2'($urandom);
        c.src_reg  = 2'($urandom);
        case ($urandom_range(0, 3))
            0: c.immediate = $urandom;
            1: c.immediate = $urandom_range(0, 16) - 8;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: c.immediate = WORD_MIN;
                    1: c.immediate = WORD_MAX;
                    2: c.immediate = WORD_ONES;
                    default: c.immediate = '0;
                endcase
            end
            default: c.immediate = $urandom_range(0, 65535) - 32768;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 24)
            c.mode = OP_IN;
        else if (pick < 32)
            c.mode = OP_MOV;
        else if (pick < 42)
            c.mode = OP_ADD;
        else if (pick < 52)
            c.mode = OP_SUB;
        else if (pick < 64)
            c.mode = OP_MUL;
        else if (pick < 78)
            c.mode = OP_DIV;
        else if (pick < 97)
            c.mode = OP_OUT;
        else
            c.mode = MODE_UNUSED;
        return c;
    endfunction

    task automatic send(cmd_t c);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    task automatic pause(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
    endtask

    // Result-side stalls come in bursts; no burst starts during a calm stretch.
    initial
    begin
        bit stall_burst;
        res_stall = 1'b0;
        forever
        begin
            stall_burst = !calm && ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 19))
            begin
                @(negedge clk);
                res_stall <= stall_burst;
            end
        end
    end

    // Ends the run when no request and no result has moved for too long.
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int   sent;
        cmd_t c;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        calm      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(instr(OP_OUT, REG_A, REG_B, '0));
        send(instr(OP_IN, REG_A, REG_D, WORD_MAX));
        send(instr(OP_IN, REG_B, REG_C, WORD_MIN));
        send(instr(OP_IN, REG_C, REG_A, WORD_ONES));
        send(instr(OP_IN, REG_D, REG_B, '0));
        send(instr(OP_DIV, REG_A, REG_D, '0));
        send(instr(OP_DIV, REG_D, REG_D, '0));
        send(instr(OP_MOV, REG_D, REG_B, '0));
        send(instr(OP_DIV, REG_D, REG_C, '0));
        send(instr(OP_OUT, REG_D, REG_A, '0));
        send(instr(OP_ADD, REG_A, REG_A, '0));
        send(instr(OP_ADD, REG_D, REG_C, '0));
        send(instr(OP_OUT, REG_D, REG_C, '0));
        send(instr(OP_MUL, REG_A, REG_D, '0));
        send(instr(OP_MUL, REG_B, REG_B, '0));
        send(instr(OP_OUT, REG_A, REG_D, '0));
        send(instr(OP_SUB, REG_C, REG_B, '0));
        send(instr(OP_OUT, REG_C, REG_B, '0));
        send(instr(OP_IN, REG_B, REG_A, -32'sd7));
        send(instr(OP_IN, REG_D, REG_A, 32'd2));
        send(instr(OP_DIV, REG_B, REG_D, '0));
        send(instr(OP_OUT, REG_B, REG_D, '0));
        send(instr(MODE_UNUSED, REG_D, REG_A, WORD_ONES));
        send(instr(OP_SUB, REG_D, REG_D, '0));
        send(instr(OP_MOV, REG_C, REG_C, '0));
        send(instr(OP_OUT, REG_D, REG_D, WORD_ONES));

        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            calm = (sent >= 500 && sent < 650) || sent >= ITEM_COUNT - 150;
            c = random_instr();
            if (!calm && $urandom_range(0, 5) == 0)
                pause($urandom_range(1, 19));
            send(c);
            sent++;
        end
        pause(1);

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hw/rtl/fram_pkg.sv
hw/rtl/fram_ctrl.sv
hw/rtl/fram_dp.sv
hw/rtl/four_register_alu_machine_unit.sv
tb/four_register_alu_machine_checker.sv
tb/four_register_alu_machine_unit_tb.sv
